[design/clockwise_neighbour_select_unit_defines.svh]
// ----------------------------------------------------------------------------
// Clockwise neighbour select assertion macros
// Shared assertion forms for the checker of the neighbour select unit.
// ----------------------------------------------------------------------------
`ifndef CLOCKWISE_NEIGHBOUR_SELECT_UNIT_DEFINES_SVH
`define CLOCKWISE_NEIGHBOUR_SELECT_UNIT_DEFINES_SVH

// Assertion that is switched off while reset is applied.
`define CNSU_ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Assertion that is also checked while reset is applied.
`define CNSU_ASSERT_RST(name, prop, msg) \
    name: assert property (@(posedge aclk) (prop)) \
        else $error(msg);

`endif

[design/cnsu_pkg.sv]
// ----------------------------------------------------------------------------
// Clockwise neighbour select package
// Payload types, pipeline item types and the cross product sign helper.
// ----------------------------------------------------------------------------
package cnsu_pkg;

    // Field widths of the transfers.
    localparam int COORD_W        = 32;
    localparam int DIFF_W         = COORD_W + 1;
    localparam int PROD_W         = 2 * DIFF_W;
    localparam int WIDE_W         = PROD_W + 1;
    localparam int IDX_W          = 8;
    localparam int MAX_POINTS_DEF = 256;

    // Sign of a cross product.
    typedef enum logic [1:0] {
        SIDE_ZERO = 2'd0,
        SIDE_POS  = 2'd1,
        SIDE_NEG  = 2'd2
    } side_t;

    // One input transfer.
    typedef struct packed {
        logic signed [COORD_W-1:0] ref_x;
        logic signed [COORD_W-1:0] ref_y;
        logic signed [COORD_W-1:0] centre_px;
        logic signed [COORD_W-1:0] centre_py;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      pick_left;
        logic                      last_point;
    } in_item_t;

    // One result transfer.
    typedef struct packed {
        logic [IDX_W-1:0] chosen_index;
        logic             overflow;
    } out_item_t;

    // Point relative to the centre, with the set control that goes with it.
    typedef struct packed {
        logic signed [DIFF_W-1:0] ndx;
        logic signed [DIFF_W-1:0] ndy;
        logic signed [DIFF_W-1:0] rdx;
        logic signed [DIFF_W-1:0] rdy;
        logic                     first;
        logic                     cmp;
        logic                     last;
        logic                     left;
        logic                     over;
    } stage_item_t;

    // Point with its side of the reference vector, ready for the tournament.
    typedef struct packed {
        logic signed [DIFF_W-1:0] ndx;
        logic signed [DIFF_W-1:0] ndy;
        side_t                    side;
        logic                     first;
        logic                     cmp;
        logic                     last;
        logic                     left;
        logic                     over;
    } pick_item_t;

    // Sign of p - q, computed exactly one bit wider than the products.
    function automatic side_t sign_of_diff(input logic signed [PROD_W-1:0] p,
                                           input logic signed [PROD_W-1:0] q);
        logic signed [WIDE_W-1:0] d;
        side_t                    s;
        d = WIDE_W'(p) - WIDE_W'(q);
        if (d[WIDE_W-1]) begin
            s = SIDE_NEG;
        end else if (d != '0) begin
            s = SIDE_POS;
        end else begin
            s = SIDE_ZERO;
        end
        return s;
    endfunction

endpackage

[design/clockwise_neighbour_select_unit.sv]
// ----------------------------------------------------------------------------
// Clockwise neighbour select unit: one point per cycle unless back-pressure
// stalls it, result on the last. The last point passes through the input,
// difference, product and side registers ahead of the result register.
// Reset (aresetn low, synchronous) empties the pipeline and the set state.
// ----------------------------------------------------------------------------
module clockwise_neighbour_select_unit #(
    parameter int MAX_POINTS = cnsu_pkg::MAX_POINTS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cnsu_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output cnsu_pkg::out_item_t m_item
);
    import cnsu_pkg::*;

    logic        prep_valid;
    logic        prep_ready;
    stage_item_t prep_item;
    logic        side_valid;
    logic        side_ready;
    pick_item_t  side_item;

    // Input register, set tracking and centre differences.
    cnsu_prep #(
        .MAX_POINTS (MAX_POINTS)
    ) u_prep (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .o_valid (prep_valid),
        .o_ready (prep_ready),
        .o_item  (prep_item)
    );

    // Side of the reference vector.
    cnsu_side u_side (
        .aclk    (aclk),
        .aresetn (aresetn),
        .i_valid (prep_valid),
        .i_ready (prep_ready),
        .i_item  (prep_item),
        .o_valid (side_valid),
        .o_ready (side_ready),
        .o_item  (side_item)
    );

    // Running tournament and result register.
    cnsu_pick #(
        .MAX_POINTS (MAX_POINTS)
    ) u_pick (
        .aclk    (aclk),
        .aresetn (aresetn),
        .i_valid (side_valid),
        .i_ready (side_ready),
        .i_item  (side_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

[design/cnsu_prep.sv]
// ----------------------------------------------------------------------------
// Clockwise neighbour select input stage
// Registers the input transfer, tracks the set and forms centre differences.
// ----------------------------------------------------------------------------
module cnsu_prep #(
    parameter int MAX_POINTS = cnsu_pkg::MAX_POINTS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  cnsu_pkg::in_item_t    s_item,
    output logic                  o_valid,
    input  logic                  o_ready,
    output cnsu_pkg::stage_item_t o_item
);
    import cnsu_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    logic                      in_valid_reg;
    in_item_t                  in_item_reg;
    logic                      out_valid_reg;
    stage_item_t               out_item_reg;
    stage_item_t               out_item_next;
    logic [CNT_W-1:0]          cnt_reg;
    logic [CNT_W-1:0]          cnt_next;
    logic                      over_reg;
    logic                      over_next;
    logic                      left_reg;
    logic signed [COORD_W-1:0] cx_reg;
    logic signed [COORD_W-1:0] cy_reg;
    logic signed [DIFF_W-1:0]  rdx_reg;
    logic signed [DIFF_W-1:0]  rdy_reg;

    logic                      adv;
    logic                      first;
    logic                      beyond;
    logic signed [COORD_W-1:0] cx_sel;
    logic signed [COORD_W-1:0] cy_sel;
    logic signed [DIFF_W-1:0]  rdx_sel;
    logic signed [DIFF_W-1:0]  rdy_sel;
    logic                      left_sel;

    // The held input moves on whenever the next register is free.
    assign adv     = in_valid_reg && (!out_valid_reg || o_ready);
    assign s_ready = !in_valid_reg || adv;
    assign o_valid = out_valid_reg;
    assign o_item  = out_item_reg;

    // Set tracking and differences from the centre.
    always_comb begin
        first    = (cnt_reg == '0);
        beyond   = !first && (cnt_reg == CNT_W'(MAX_POINTS));
        cx_sel   = first ? in_item_reg.centre_px : cx_reg;
        cy_sel   = first ? in_item_reg.centre_py : cy_reg;
        rdx_sel  = first ? (DIFF_W'(in_item_reg.ref_x) - DIFF_W'(in_item_reg.centre_px))
                         : rdx_reg;
        rdy_sel  = first ? (DIFF_W'(in_item_reg.ref_y) - DIFF_W'(in_item_reg.centre_py))
                         : rdy_reg;
        left_sel = first ? in_item_reg.pick_left : left_reg;

        out_item_next.ndx   = DIFF_W'(in_item_reg.point_x) - DIFF_W'(cx_sel);
        out_item_next.ndy   = DIFF_W'(in_item_reg.point_y) - DIFF_W'(cy_sel);
        out_item_next.rdx   = rdx_sel;
        out_item_next.rdy   = rdy_sel;
        out_item_next.first = first;
        out_item_next.cmp   = !first && !beyond;
        out_item_next.last  = in_item_reg.last_point;
        out_item_next.left  = left_sel;
        out_item_next.over  = !first && (over_reg || beyond);

        if (in_item_reg.last_point || first) begin
            over_next = 1'b0;
        end else begin
            over_next = over_reg || beyond;
        end

        if (in_item_reg.last_point) begin
            cnt_next = '0;
        end else if (first) begin
            cnt_next = CNT_W'(1);
        end else if (beyond) begin
            cnt_next = cnt_reg;
        end else begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            over_reg      <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (adv) begin
                out_valid_reg <= 1'b1;
                cnt_reg       <= cnt_next;
                over_reg      <= over_next;
            end else if (o_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload and the values latched from the first point of a set.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (adv) begin
            out_item_reg <= out_item_next;
            left_reg     <= left_sel;
            cx_reg       <= cx_sel;
            cy_reg       <= cy_sel;
            rdx_reg      <= rdx_sel;
            rdy_reg      <= rdy_sel;
        end
    end

endmodule

[design/cnsu_side.sv]
// ----------------------------------------------------------------------------
// Clockwise neighbour select side stage
// Cross product of each point with the reference vector, over two stages.
// ----------------------------------------------------------------------------
module cnsu_side (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  i_valid,
    output logic                  i_ready,
    input  cnsu_pkg::stage_item_t i_item,
    output logic                  o_valid,
    input  logic                  o_ready,
    output cnsu_pkg::pick_item_t  o_item
);
    import cnsu_pkg::*;

    logic                     v3_reg;
    stage_item_t              item3_reg;
    logic signed [PROD_W-1:0] p3_reg;
    logic signed [PROD_W-1:0] q3_reg;
    logic                     v4_reg;
    pick_item_t               item4_reg;
    pick_item_t               item4_next;
    logic                     take4;

    assign take4   = !v4_reg || o_ready;
    assign i_ready = !v3_reg || take4;
    assign o_valid = v4_reg;
    assign o_item  = item4_reg;

    // Side of the reference vector from the registered products.
    always_comb begin
        item4_next.ndx   = item3_reg.ndx;
        item4_next.ndy   = item3_reg.ndy;
        item4_next.side  = sign_of_diff(p3_reg, q3_reg);
        item4_next.first = item3_reg.first;
        item4_next.cmp   = item3_reg.cmp;
        item4_next.last  = item3_reg.last;
        item4_next.left  = item3_reg.left;
        item4_next.over  = item3_reg.over;
    end

    // Stage valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (i_ready) begin
                v3_reg <= i_valid;
            end
            if (take4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    // Products are registered before the subtraction.
    always_ff @(posedge aclk) begin
        if (i_valid && i_ready) begin
            item3_reg <= i_item;
            p3_reg    <= PROD_W'(i_item.ndx) * PROD_W'(i_item.rdy);
            q3_reg    <= PROD_W'(i_item.rdx) * PROD_W'(i_item.ndy);
        end
        if (take4 && v3_reg) begin
            item4_reg <= item4_next;
        end
    end

endmodule

[design/cnsu_pick.sv]
// ----------------------------------------------------------------------------
// Clockwise neighbour select tournament
// Compares each point with the current best and registers the result.
// ----------------------------------------------------------------------------
module cnsu_pick #(
    parameter int MAX_POINTS = cnsu_pkg::MAX_POINTS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 i_valid,
    output logic                 i_ready,
    input  cnsu_pkg::pick_item_t i_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output cnsu_pkg::out_item_t  m_item
);
    import cnsu_pkg::*;

    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int SLOT_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int EXT_W  = (SLOT_W > IDX_W) ? SLOT_W : IDX_W;

    logic signed [DIFF_W-1:0] best_dx_reg;
    logic signed [DIFF_W-1:0] best_dx_next;
    logic signed [DIFF_W-1:0] best_dy_reg;
    logic signed [DIFF_W-1:0] best_dy_next;
    side_t                    best_side_reg;
    side_t                    best_side_next;
    logic [SLOT_W-1:0]        slot_reg;
    logic [SLOT_W-1:0]        slot_next;
    logic [CNT_W-1:0]         cnt_reg;
    logic [CNT_W-1:0]         cnt_next;
    logic                     m_valid_reg;
    out_item_t                m_item_reg;
    out_item_t                m_item_next;

    logic                     out_free;
    logic                     fire;
    logic signed [PROD_W-1:0] pair_p;
    logic signed [PROD_W-1:0] pair_q;
    side_t                    pair_side;
    logic                     same_side;
    logic                     take_raw;
    logic                     take_new;
    logic [EXT_W-1:0]         slot_ext;

    // A point that ends a set waits until the result register is free.
    assign out_free = !m_valid_reg || m_ready;
    assign i_ready  = !i_valid || !i_item.last || out_free;
    assign fire     = i_valid && i_ready;
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;

    // Comparison of the new point with the best one so far.
    always_comb begin
        pair_p    = PROD_W'(best_dx_reg) * PROD_W'(i_item.ndy);
        pair_q    = PROD_W'(i_item.ndx) * PROD_W'(best_dy_reg);
        pair_side = sign_of_diff(pair_p, pair_q);
        same_side = ((best_side_reg == SIDE_POS) && (i_item.side == SIDE_POS)) ||
                    ((best_side_reg == SIDE_NEG) && (i_item.side == SIDE_NEG));
        if (same_side) begin
            take_raw = (pair_side != SIDE_NEG);
        end else begin
            take_raw = (best_side_reg != SIDE_POS);
        end
        take_new = i_item.left ? take_raw : !take_raw;

        best_dx_next   = best_dx_reg;
        best_dy_next   = best_dy_reg;
        best_side_next = best_side_reg;
        slot_next      = slot_reg;
        cnt_next       = cnt_reg;
        if (i_item.first) begin
            best_dx_next   = i_item.ndx;
            best_dy_next   = i_item.ndy;
            best_side_next = i_item.side;
            slot_next      = '0;
            cnt_next       = CNT_W'(1);
        end else if (i_item.cmp) begin
            if (take_new) begin
                best_dx_next   = i_item.ndx;
                best_dy_next   = i_item.ndy;
                best_side_next = i_item.side;
                slot_next      = cnt_reg[SLOT_W-1:0];
            end
            cnt_next = cnt_reg + CNT_W'(1);
        end

        // The index carries the low bits of the chosen position.
        slot_ext                 = EXT_W'(slot_next);
        m_item_next.chosen_index = slot_ext[IDX_W-1:0];
        m_item_next.overflow     = i_item.over;
    end

    // Result valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (fire && i_item.last) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Tournament state and result payload.
    always_ff @(posedge aclk) begin
        if (fire) begin
            best_dx_reg   <= best_dx_next;
            best_dy_reg   <= best_dy_next;
            best_side_reg <= best_side_next;
            slot_reg      <= slot_next;
            cnt_reg       <= cnt_next;
        end
        if (fire && i_item.last) begin
            m_item_reg <= m_item_next;
        end
    end

endmodule

[design/cnsu_checker.sv]
// ----------------------------------------------------------------------------
// Clockwise neighbour select checker
// Port level assertions on reset, latency and result transfers.
// ----------------------------------------------------------------------------
`include "clockwise_neighbour_select_unit_defines.svh"

module cnsu_checker #(
    parameter int MAX_POINTS = cnsu_pkg::MAX_POINTS_DEF
) (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input cnsu_pkg::in_item_t  s_item,
    input logic                m_valid,
    input logic                m_ready,
    input cnsu_pkg::out_item_t m_item
);
    import cnsu_pkg::*;

    // A stalled result holds its payload.
    `CNSU_ASSERT_CLK(a_result_hold, m_valid && !m_ready |=> m_valid && $stable(m_item), "result changed while stalled")

    // Reset empties the block and opens the input.
    `CNSU_ASSERT_RST(a_reset_clear, !aresetn |=> !m_valid && s_ready, "reset did not clear the block")

    // After reset, no result reaches the output before points can fill the pipeline.
    `CNSU_ASSERT_RST(a_reset_latency, !aresetn |=> !m_valid ##1 !m_valid ##1 !m_valid ##1 !m_valid, "result too soon after reset")

    // A chosen position lies inside the set capacity.
    `CNSU_ASSERT_CLK(a_index_range, m_valid |-> (MAX_POINTS > 256) || (int'(m_item.chosen_index) < MAX_POINTS), "chosen index beyond capacity")

endmodule

bind clockwise_neighbour_select_unit cnsu_checker #(
    .MAX_POINTS (MAX_POINTS)
) u_checker (.*);

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Clockwise neighbour select unit testbench
// Streams sets of neighbour points through the unit and checks each chosen
// index and overflow flag against a local tournament model that tracks the
// latched reference vector, the centre and the current best point.
// ----------------------------------------------------------------------------
module tb;
    import cnsu_pkg::*;

    localparam int CAPACITY     = MAX_POINTS_DEF;
    localparam int DRAIN_CYCLES = 12;

    // Clock, reset and the two channels.
    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    clockwise_neighbour_select_unit #(
        .MAX_POINTS (CAPACITY)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // Tournament state of the local model.
    logic signed [DIFF_W-1:0]  axis_dx   = '0;
    logic signed [DIFF_W-1:0]  axis_dy   = '0;
    logic signed [DIFF_W-1:0]  hub_x     = '0;
    logic signed [DIFF_W-1:0]  hub_y     = '0;
    logic signed [DIFF_W-1:0]  leader_dx = '0;
    logic signed [DIFF_W-1:0]  leader_dy = '0;
    side_t                     leader_side = SIDE_ZERO;
    int                        leader_pos  = 0;
    int                        points_in_set = 0;
    bit                        left_mode   = 1'b0;
    bit                        set_overrun = 1'b0;

    // Chosen indexes still to arrive, oldest first.
    out_item_t pending_picks[$];

    int  fail_count    = 0;
    int  items_sent    = 0;
    int  sets_sent     = 0;
    int  overrun_sets  = 0;
    int  results_seen  = 0;
    bit  calm          = 1'b0;

    // 4 ns clock.
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Generous overall time limit.
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Sign of a*b - c*d, worked out exactly at a width that cannot overflow.
    function automatic side_t cross_side(input logic signed [DIFF_W-1:0] a,
                                         input logic signed [DIFF_W-1:0] b,
                                         input logic signed [DIFF_W-1:0] c,
                                         input logic signed [DIFF_W-1:0] d);
        logic signed [PROD_W+1:0] wa, wb, wc, wd, r;
        side_t                    s;
        wa = a;
        wb = b;
        wc = c;
        wd = d;
        r  = wa * wb - wc * wd;
        if (r < 0) begin
            s = SIDE_NEG;
        end else if (r != 0) begin
            s = SIDE_POS;
        end else begin
            s = SIDE_ZERO;
        end
        return s;
    endfunction

    // Advances the tournament by one accepted point and queues the pick on the last.
    function automatic void track_point(input in_item_t it);
        logic signed [DIFF_W-1:0] px, py, rx, ry, ndx, ndy;
        side_t                    nside;
        bit                       take;
        out_item_t                pick;
        px = $signed(it.point_x);
        py = $signed(it.point_y);
        if (points_in_set == 0) begin
            hub_x       = $signed(it.centre_px);
            hub_y       = $signed(it.centre_py);
            rx          = $signed(it.ref_x);
            ry          = $signed(it.ref_y);
            axis_dx     = rx - hub_x;
            axis_dy     = ry - hub_y;
            left_mode   = it.pick_left;
            set_overrun = 1'b0;
            leader_dx   = px - hub_x;
            leader_dy   = py - hub_y;
            leader_side = cross_side(leader_dx, axis_dy, axis_dx, leader_dy);
            leader_pos  = 0;
            points_in_set = 1;
        end else if (points_in_set < CAPACITY) begin
            ndx   = px - hub_x;
            ndy   = py - hub_y;
            nside = cross_side(ndx, axis_dy, axis_dx, ndy);
            // Same strict side: the pairwise cross product decides.
            if ((leader_side == SIDE_POS && nside == SIDE_POS) ||
                (leader_side == SIDE_NEG && nside == SIDE_NEG)) begin
                take = cross_side(leader_dx, ndy, ndx, leader_dy) != SIDE_NEG;
            end else begin
                take = leader_side != SIDE_POS;
            end
            if (!left_mode) begin
                take = !take;
            end
            if (take) begin
                leader_dx   = ndx;
                leader_dy   = ndy;
                leader_side = nside;
                leader_pos  = points_in_set;
            end
            points_in_set++;
        end else begin
            set_overrun = 1'b1;
        end
        if (it.last_point) begin
            pick.chosen_index = leader_pos[IDX_W-1:0];
            pick.overflow     = set_overrun;
            pending_picks.push_back(pick);
            if (set_overrun) begin
                overrun_sets++;
            end
            sets_sent++;
            points_in_set = 0;
        end
    endfunction

    // Compares every result transfer with the oldest pending pick.
    always @(posedge aclk) begin : check_results
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_picks.size() == 0) begin
                $error("Result with nothing pending: chosen_index %0d, overflow %0b",
                       m_item.chosen_index, m_item.overflow);
                fail_count++;
            end else begin
                want = pending_picks.pop_front();
                results_seen++;
                if (m_item.chosen_index !== want.chosen_index) begin
                    $error("chosen_index: expected %0d, actual %0d",
                           want.chosen_index, m_item.chosen_index);
                    fail_count++;
                end
                if (m_item.overflow !== want.overflow) begin
                    $error("overflow: expected %0b, actual %0b",
                           want.overflow, m_item.overflow);
                    fail_count++;
                end
            end
        end
    end

    // Result side back-pressure in short random bursts.
    initial begin : result_backpressure
        int hold;
        @(posedge aclk);
        forever begin
            if (!calm && $urandom_range(0, 4) == 0) begin
                hold = $urandom_range(1, 4);
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    // Offers one point and holds it until the transfer, then maybe idles.
    task automatic send_point(input in_item_t it);
        int gap;
        s_item  <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        track_point(it);
        items_sent++;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 4);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stops sending and waits until every pending pick has been checked.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (pending_picks.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic in_item_t make_point(input int rx, input int ry,
                                            input int cx, input int cy,
                                            input int px, input int py,
                                            input bit pick, input bit last);
        in_item_t it;
        it.ref_x      = rx;
        it.ref_y      = ry;
        it.centre_px  = cx;
        it.centre_py  = cy;
        it.point_x    = px;
        it.point_y    = py;
        it.pick_left  = pick;
        it.last_point = last;
        return it;
    endfunction

    // Coordinate styles: full range, a small window, or the extremes.
    function automatic logic signed [COORD_W-1:0] rand_coord(input int style);
        logic signed [COORD_W-1:0] v;
        case (style)
            0: v = $urandom;
            1: v = int'($urandom_range(0, 16)) - 8;
            default: begin
                case ($urandom_range(0, 4))
                    0: v = 32'sh7fff_ffff;
                    1: v = 32'sh8000_0000;
                    2: v = '0;
                    3: v = -1;
                    default: v = $urandom;
                endcase
            end
        endcase
        return v;
    endfunction

    // Sends a set of n random points; the non-latched fields carry noise.
    task automatic send_set(input int n, input int style);
        in_item_t it;
        for (int k = 0; k < n; k++) begin
            it.ref_x      = rand_coord(style);
            it.ref_y      = rand_coord(style);
            it.centre_px  = rand_coord(style);
            it.centre_py  = rand_coord(style);
            it.point_x    = rand_coord(style);
            it.point_y    = rand_coord(style);
            it.pick_left  = 1'($urandom_range(0, 1));
            it.last_point = (k == n - 1);
            send_point(it);
        end
    endtask

    function automatic int rand_set_size();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return 1;
        end else if (r < 8) begin
            return $urandom_range(2, 8);
        end else if (r == 8) begin
            return $urandom_range(9, 24);
        end
        return $urandom_range(25, 60);
    endfunction

    // Single-point sets, mixed and matching sides, collinear points and extremes.
    task automatic test_directed_corners();
        // Single-point sets at the coordinate extremes, both directions.
        send_point(make_point(32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000,
                              32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 1, 1));
        send_point(make_point(-1, 0, 32'sh7fff_ffff, 32'sh8000_0000,
                              32'sh8000_0000, 32'sh7fff_ffff, 0, 1));
        // Points on both sides, on the reference line and at the centre.
        for (int dir = 1; dir >= 0; dir--) begin
            send_point(make_point(1, 0, 0, 0, 0, 1, 1'(dir), 0));
            send_point(make_point(99, -7, 3, 3, 0, -1, 0, 0));
            send_point(make_point(-5, 42, 8, 8, 1, 1, 1, 0));
            send_point(make_point(0, 0, 0, 0, -1, -1, 0, 0));
            send_point(make_point(7, 7, 7, 7, 3, 0, 1, 0));
            send_point(make_point(1, 1, 1, 1, 0, 0, 0, 1));
        end
        // Widest differences from the centre.
        send_point(make_point(32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000,
                              32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 1, 0));
        send_point(make_point(0, 0, 0, 0, 32'sh8000_0000, 32'sh8000_0000, 0, 0));
        send_point(make_point(0, 0, 0, 0, 32'sh7fff_ffff, 32'sh8000_0000, 0, 1));
        // Collinear contenders on the same side tie on the pairwise product.
        send_point(make_point(10, 5, 5, 5, 6, 8, 1, 0));
        send_point(make_point(0, 0, 0, 0, 7, 11, 0, 0));
        send_point(make_point(0, 0, 0, 0, 7, 2, 0, 1));
        wait_for_results();
    endtask

    // Random sets of mixed sizes and styles, with one full pause midway.
    task automatic test_random_sets(input int target);
        bit paused;
        paused = 1'b0;
        while (items_sent < target) begin
            send_set(rand_set_size(), $urandom_range(0, 2));
            if (!paused && items_sent >= target / 2) begin
                wait_for_results();
                paused = 1'b1;
            end
        end
        wait_for_results();
    endtask

    // A set exactly at capacity, then sets past it, then a short set to clear the flag.
    task automatic test_capacity_overflow();
        send_set(CAPACITY, 1);
        send_set(CAPACITY + 1, 0);
        send_set(CAPACITY + 14, 2);
        send_set(3, 1);
        wait_for_results();
    endtask

    // Back-to-back transfers with the result side always ready.
    task automatic test_settled_stream(input int n_sets);
        calm = 1'b1;
        for (int k = 0; k < n_sets; k++) begin
            send_set(rand_set_size(), $urandom_range(0, 2));
        end
        wait_for_results();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_corners();
        test_random_sets(480);
        test_capacity_overflow();
        test_settled_stream(20);

        $display("Sent %0d points in %0d sets (%0d past capacity).",
                 items_sent, sets_sent, overrun_sets);
        $display("Checked %0d chosen indexes under random idling and back-pressure.",
                 results_seen);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
